// ===== hdl/accel_tilt_pitch_roll_macros.svh =====
// assertion macros for the accelerometer tilt block
`ifndef ACCEL_TILT_PITCH_ROLL_MACROS_SVH
`define ACCEL_TILT_PITCH_ROLL_MACROS_SVH
`ifndef SYNTHESIS
`define ATPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ATPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ATPR_ASSERT(lbl, prop, msg)
`define ATPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/atpr_pkg.sv =====
// shared constants, types and tables of the accelerometer tilt block
package atpr_pkg;
    localparam int GAIN_W  = 20;
    localparam int ACC_W   = 28;
    localparam int ANG_W   = 16;
    localparam int OANG_W  = 17;
    localparam int CORDIC_ITER_DEF = 16;

    localparam logic [GAIN_W-1:0] GAIN_X_RST = 20'd63148;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST = 20'd63084;
    localparam logic [GAIN_W-1:0] GAIN_Z_RST = 20'd58597;

    localparam logic signed [ANG_W-1:0] DEG_LIMIT = 16'sd23040;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_ZERO   = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    localparam logic [1:0] REG_GAIN_X = 2'd0;
    localparam logic [1:0] REG_GAIN_Y = 2'd1;
    localparam logic [1:0] REG_GAIN_Z = 2'd2;

    typedef struct packed {
        logic idle;
        logic done;
    } atpr_stat_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [22:0] atan_entry(input logic [4:0] idx);
        logic [22:0] v;
        unique case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // clamp an angle to +-90 degrees
    function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [17:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > 18'sd23040) begin
            r = DEG_LIMIT;
        end else if (v < -18'sd23040) begin
            r = -DEG_LIMIT;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction
endpackage

// ===== hdl/atpr_core.sv =====
// iterative datapath: axis scaling, squares, integer sqrt and cordic atan2
module atpr_core #(
    parameter int CORDIC_ITERATIONS = atpr_pkg::CORDIC_ITER_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [15:0]                   raw_x,
    input  logic signed [15:0]                   raw_y,
    input  logic signed [15:0]                   raw_z,
    input  logic [atpr_pkg::GAIN_W-1:0]          gain_x,
    input  logic [atpr_pkg::GAIN_W-1:0]          gain_y,
    input  logic [atpr_pkg::GAIN_W-1:0]          gain_z,
    output logic signed [atpr_pkg::ACC_W-1:0]    accel_x,
    output logic signed [atpr_pkg::ACC_W-1:0]    accel_y,
    output logic signed [atpr_pkg::ACC_W-1:0]    accel_z,
    output logic signed [atpr_pkg::ANG_W-1:0]    pitch_abs,
    output logic signed [atpr_pkg::ANG_W-1:0]    roll_abs,
    output atpr_pkg::atpr_stat_t                 stat
);
    import atpr_pkg::*;

    localparam int ITW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_LD, S_SQRT, S_NORM, S_ROT, S_FIN, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [2:0]                op_reg;
    logic                      pass_reg;
    logic [ITW-1:0]            iter_reg;
    logic signed [15:0]        raw_x_reg, raw_y_reg, raw_z_reg;
    logic signed [ACC_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [54:0]               sqx_reg, sqy_reg, sqz_reg;
    logic [55:0]               rem_reg;
    logic [56:0]               root_reg;
    logic [54:0]               bit_reg;
    logic signed [43:0]        x_reg, y_reg;
    logic signed [25:0]        z_reg;
    logic signed [ANG_W-1:0]   pitch_reg, roll_reg;

    logic signed [27:0]        mul_a, mul_b;
    logic signed [55:0]        prod, rnd;
    logic [55:0]               sum_p, sum_r;
    logic [56:0]               trial;
    logic                      take;
    logic [56:0]               root_step;
    logic [43:0]               mag_x, mag_y, mag_m;
    logic signed [43:0]        dx, dy;
    logic signed [25:0]        tab;
    logic signed [25:0]        z_rnd;
    logic signed [ANG_W-1:0]   ang;
    logic signed [ACC_W-1:0]   num;

    // one shared multiplier, operands picked by step
    always_comb begin
        unique case (op_reg)
            3'd0: begin
                mul_a = 28'(raw_x_reg);
                mul_b = {8'd0, gain_x};
            end
            3'd1: begin
                mul_a = 28'(raw_y_reg);
                mul_b = {8'd0, gain_y};
            end
            3'd2: begin
                mul_a = 28'(raw_z_reg);
                mul_b = {8'd0, gain_z};
            end
            3'd3: begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            3'd4: begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            3'd5: begin
                mul_a = az_reg;
                mul_b = az_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign rnd   = prod + 56'sd128;
    assign sum_p = {1'b0, sqy_reg} + {1'b0, sqz_reg};
    assign sum_r = {1'b0, sqx_reg} + {1'b0, sqz_reg};

    // one digit of the square root per cycle
    assign trial     = root_reg + {2'b00, bit_reg};
    assign take      = {1'b0, rem_reg} >= trial;
    assign root_step = take ? ((root_reg >> 1) + {2'b00, bit_reg}) : (root_reg >> 1);

    assign num   = pass_reg ? ay_reg : ax_reg;
    assign mag_x = x_reg[43] ? 44'(-x_reg) : 44'(x_reg);
    assign mag_y = y_reg[43] ? 44'(-y_reg) : 44'(y_reg);
    assign mag_m = (mag_x > mag_y) ? mag_x : mag_y;

    assign dx    = y_reg >>> iter_reg;
    assign dy    = x_reg >>> iter_reg;
    assign tab   = 26'(atan_entry(5'(iter_reg)));
    assign z_rnd = z_reg + 26'sd128;
    assign ang   = clamp_ang(z_rnd[25:8]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            pass_reg  <= 1'b0;
            iter_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        raw_x_reg <= raw_x;
                        raw_y_reg <= raw_y;
                        raw_z_reg <= raw_z;
                        op_reg    <= '0;
                        pass_reg  <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (op_reg)
                        3'd0: ax_reg <= rnd[35:8];
                        3'd1: ay_reg <= rnd[35:8];
                        3'd2: az_reg <= rnd[35:8];
                        3'd3: sqx_reg <= prod[54:0];
                        3'd4: sqy_reg <= prod[54:0];
                        default: sqz_reg <= prod[54:0];
                    endcase
                    op_reg <= op_reg + 3'd1;
                    if (op_reg == 3'd5) begin
                        state_reg <= S_LD;
                    end
                end
                S_LD: begin
                    rem_reg   <= pass_reg ? sum_r : sum_p;
                    root_reg  <= '0;
                    bit_reg   <= 55'd1 << 54;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (take) begin
                        rem_reg <= rem_reg - trial[55:0];
                    end
                    root_reg <= root_step;
                    bit_reg  <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        x_reg     <= {1'b0, root_step[42:0]};
                        y_reg     <= 44'(num);
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    // bring the larger magnitude into [2^40, 2^41)
                    if (mag_m == '0) begin
                        z_reg     <= '0;
                        state_reg <= S_FIN;
                    end else if (mag_m[43:32] == '0) begin
                        x_reg <= x_reg <<< 8;
                        y_reg <= y_reg <<< 8;
                    end else if (mag_m[43:40] == '0) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        z_reg     <= '0;
                        iter_reg  <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (!y_reg[43]) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + tab;
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - tab;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITW'(CORDIC_ITERATIONS - 1)) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!pass_reg) begin
                        pitch_reg <= ang;
                        pass_reg  <= 1'b1;
                        state_reg <= S_LD;
                    end else begin
                        roll_reg  <= ang;
                        state_reg <= S_DONE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign accel_x   = ax_reg;
    assign accel_y   = ay_reg;
    assign accel_z   = az_reg;
    assign pitch_abs = pitch_reg;
    assign roll_abs  = roll_reg;
    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
endmodule

// ===== hdl/accel_tilt_pitch_roll.sv =====
// top level of the accelerometer tilt block: command handling, offsets, result register
//
// input words carry a command in s_tuser and three raw axis samples plus two
// offsets in s_tdata; each accepted word yields exactly one result word on m_*
// - sample: scales the axes by the gain registers, computes pitch and roll with
//   an iterative unit (one multiplier, one sqrt digit or one cordic step a cycle)
// - capture zero: stores the last absolute angles as offsets, reports them
// - load offsets: stores the clamped input offsets
// the user must write gains through cfg_we / cfg_idx / cfg_wdata only while idle;
// the block itself does not enforce this; a sample word passes through the multiply
// steps, then per angle a load, the sqrt digits, the normalize steps, the cordic
// rotations (skipped for a zero vector) and a rounding step, on the shared datapath
// in atpr_core; other commands register their result word at the accepting edge
// one word is worked on at a time; s_tready is low while a sample is computed
// and while an earlier result is still held against a low m_tready
// the result register holds its word until taken, so stalls lose nothing
// reset restores the default gains and clears the angles, offsets, stored
// accelerations and m_tvalid; m_tdata is not reset
module accel_tilt_pitch_roll #(
    parameter int CORDIC_ITERATIONS = atpr_pkg::CORDIC_ITER_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // raw_x, raw_y, raw_z, pitch_offset_in, roll_offset_in
    input  logic [79:0]  s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_x, accel_y, accel_z, pitch, roll, pitch_offset, roll_offset, zero pad
    output logic [151:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_idx,
    input  logic [atpr_pkg::GAIN_W-1:0] cfg_wdata
);
    import atpr_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_OUT} state_t;

    state_t                  st_reg, st_next;
    logic [GAIN_W-1:0]       gain_x_reg, gain_y_reg, gain_z_reg;
    logic signed [ACC_W-1:0] lax_reg, lay_reg, laz_reg;
    logic signed [ACC_W-1:0] lax_next, lay_next, laz_next;
    logic signed [ANG_W-1:0] lap_reg, lar_reg, lap_next, lar_next;
    logic signed [ANG_W-1:0] pitch_base_reg, roll_base_reg;
    logic signed [ANG_W-1:0] pitch_base_next, roll_base_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [151:0]            m_tdata_reg, m_tdata_next;

    logic                    s_accept;
    logic                    out_free;
    logic                    core_start;
    logic                    load_out;
    logic                    report_abs;
    logic signed [OANG_W-1:0] p_out, r_out;
    logic signed [ACC_W-1:0] c_ax, c_ay, c_az;
    logic signed [ANG_W-1:0] c_pitch, c_roll;
    atpr_stat_t              core_stat;
    logic                    base_ok;

    logic [1:0]              in_cmd;
    logic signed [15:0]      in_poff, in_roff;

    assign in_cmd  = s_tuser;
    assign in_poff = s_tdata[63:48];
    assign in_roff = s_tdata[79:64];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (st_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    atpr_core #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (core_start),
        .raw_x     (s_tdata[15:0]),
        .raw_y     (s_tdata[31:16]),
        .raw_z     (s_tdata[47:32]),
        .gain_x    (gain_x_reg),
        .gain_y    (gain_y_reg),
        .gain_z    (gain_z_reg),
        .accel_x   (c_ax),
        .accel_y   (c_ay),
        .accel_z   (c_az),
        .pitch_abs (c_pitch),
        .roll_abs  (c_roll),
        .stat      (core_stat)
    );

    always_comb begin
        st_next         = st_reg;
        lax_next        = lax_reg;
        lay_next        = lay_reg;
        laz_next        = laz_reg;
        lap_next        = lap_reg;
        lar_next        = lar_reg;
        pitch_base_next = pitch_base_reg;
        roll_base_next  = roll_base_reg;
        core_start      = 1'b0;
        load_out        = 1'b0;
        report_abs      = 1'b0;

        unique case (st_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_cmd)
                        CMD_SAMPLE: begin
                            core_start = 1'b1;
                            st_next    = ST_BUSY;
                        end
                        CMD_ZERO: begin
                            pitch_base_next = lap_reg;
                            roll_base_next  = lar_reg;
                            report_abs      = 1'b1;
                            load_out        = 1'b1;
                        end
                        CMD_LOAD: begin
                            pitch_base_next = clamp_ang(18'(in_poff));
                            roll_base_next  = clamp_ang(18'(in_roff));
                            load_out        = 1'b1;
                        end
                        default: begin
                            // unused command: report the state as it stands
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_BUSY: begin
                if (core_stat.done) begin
                    lax_next = c_ax;
                    lay_next = c_ay;
                    laz_next = c_az;
                    lap_next = c_pitch;
                    lar_next = c_roll;
                    st_next  = ST_OUT;
                end
            end
            default: begin
                if (out_free) begin
                    load_out = 1'b1;
                    st_next  = ST_IDLE;
                end
            end
        endcase

        // angle against the (possibly new) base, or absolute after a capture
        if (report_abs) begin
            p_out = 17'(lap_next);
            r_out = 17'(lar_next);
        end else begin
            p_out = 17'(lap_next) - 17'(pitch_base_next);
            r_out = 17'(lar_next) - 17'(roll_base_next);
        end

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, roll_base_next, pitch_base_next, r_out, p_out,
                             laz_next, lay_next, lax_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            gain_x_reg     <= GAIN_X_RST;
            gain_y_reg     <= GAIN_Y_RST;
            gain_z_reg     <= GAIN_Z_RST;
            lax_reg        <= '0;
            lay_reg        <= '0;
            laz_reg        <= '0;
            lap_reg        <= '0;
            lar_reg        <= '0;
            pitch_base_reg <= '0;
            roll_base_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            st_reg         <= st_next;
            lax_reg        <= lax_next;
            lay_reg        <= lay_next;
            laz_reg        <= laz_next;
            lap_reg        <= lap_next;
            lar_reg        <= lar_next;
            pitch_base_reg <= pitch_base_next;
            roll_base_reg  <= roll_base_next;
            m_tvalid_reg   <= m_tvalid_next;
            // gain registers, an index past the list is ignored
            if (cfg_we) begin
                unique case (cfg_idx)
                    REG_GAIN_X: gain_x_reg <= cfg_wdata;
                    REG_GAIN_Y: gain_y_reg <= cfg_wdata;
                    REG_GAIN_Z: gain_z_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // both offsets inside +-90 degrees
    assign base_ok = (pitch_base_reg <= DEG_LIMIT) && (pitch_base_reg >= -DEG_LIMIT) &&
                     (roll_base_reg <= DEG_LIMIT) && (roll_base_reg >= -DEG_LIMIT);

`include "accel_tilt_pitch_roll_macros.svh"

    `ATPR_ASSERT(a_ready_core_idle, s_tready |-> core_stat.idle, "ready while core busy")
    `ATPR_ASSERT(a_done_in_busy, core_stat.done |-> (st_reg == ST_BUSY), "core done outside busy")
    `ATPR_ASSERT(a_base_range, base_ok, "offset out of range")
    `ATPR_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")
endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the accelerometer tilt block
`timescale 1ns / 100ps

module testbench;
    import atpr_pkg::*;

    localparam int ITERS       = CORDIC_ITER_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_WORDS  = 1300;

    // expected content of one result word
    typedef struct {
        logic signed [ACC_W-1:0]  acc_x;
        logic signed [ACC_W-1:0]  acc_y;
        logic signed [ACC_W-1:0]  acc_z;
        logic signed [OANG_W-1:0] pitch;
        logic signed [OANG_W-1:0] roll;
        logic signed [ANG_W-1:0]  pitch_ofs;
        logic signed [ANG_W-1:0]  roll_ofs;
    } tilt_word_t;

    // tilt predictor and store of expected words
    class tilt_scoreboard;
        tilt_word_t  expected_words[$];
        int          errors;
        logic [GAIN_W-1:0] gain[3];
        longint      acc_last[3];
        longint      abs_pitch, abs_roll, base_pitch, base_roll;
        longint      atan_deg[24];

        function new();
            atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
            gain = '{GAIN_X_RST, GAIN_Y_RST, GAIN_Z_RST};
            foreach (acc_last[i]) acc_last[i] = 0;
            abs_pitch = 0; abs_roll = 0; base_pitch = 0; base_roll = 0;
            errors = 0;
        endfunction

        function void set_gain(int idx, logic [GAIN_W-1:0] value);
            gain[idx] = value;
        endfunction

        function longint limit_deg(longint v);
            if (v > 23040) return 23040;
            if (v < -23040) return -23040;
            return v;
        endfunction

        function longint floor_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // vectoring cordic atan2(num, den), den >= 0, result in 1/256 degree
        function longint tilt_angle(longint num, longint den);
            longint x, y, z, dx, dy, mx, my;
            x = den; y = num; z = 0;
            if (x == 0 && y == 0) return 0;
            forever begin
                mx = (x < 0) ? -x : x;
                my = (y < 0) ? -y : y;
                if (((mx > my) ? mx : my) >= (64'sd1 <<< 40)) break;
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < ITERS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_deg[i];
                end else begin
                    x -= dx; y += dy; z -= atan_deg[i];
                end
            end
            return limit_deg((z + 128) >>> 8);
        endfunction

        function void note_word(logic [1:0] cmd, logic [79:0] data);
            tilt_word_t w;
            longint raw, p, r;
            if (cmd == CMD_SAMPLE) begin
                for (int a = 0; a < 3; a++) begin
                    raw = longint'($signed(data[16*a +: 16]));
                    acc_last[a] = (raw * longint'(gain[a]) + 128) >>> 8;
                end
                abs_pitch = tilt_angle(acc_last[0], floor_sqrt(
                    acc_last[1] * acc_last[1] + acc_last[2] * acc_last[2]));
                abs_roll = tilt_angle(acc_last[1], floor_sqrt(
                    acc_last[0] * acc_last[0] + acc_last[2] * acc_last[2]));
            end else if (cmd == CMD_ZERO) begin
                base_pitch = abs_pitch;
                base_roll  = abs_roll;
            end else if (cmd == CMD_LOAD) begin
                base_pitch = limit_deg(longint'($signed(data[63:48])));
                base_roll  = limit_deg(longint'($signed(data[79:64])));
            end
            if (cmd == CMD_ZERO) begin
                p = abs_pitch;
                r = abs_roll;
            end else begin
                p = abs_pitch - base_pitch;
                r = abs_roll - base_roll;
            end
            w.acc_x = acc_last[0][ACC_W-1:0];
            w.acc_y = acc_last[1][ACC_W-1:0];
            w.acc_z = acc_last[2][ACC_W-1:0];
            w.pitch = p[OANG_W-1:0];
            w.roll  = r[OANG_W-1:0];
            w.pitch_ofs = base_pitch[ANG_W-1:0];
            w.roll_ofs  = base_roll[ANG_W-1:0];
            expected_words.push_back(w);
        endfunction

        function void check_word(logic [151:0] d);
            tilt_word_t w;
            if (expected_words.size() == 0) begin
                $display("%0t: result word with none expected: %h", $time, d);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (d[27:0] !== w.acc_x) begin
                $display("%0t: accel_x expected %0d got %0d", $time, w.acc_x,
                         $signed(d[27:0]));
                errors++;
            end
            if (d[55:28] !== w.acc_y) begin
                $display("%0t: accel_y expected %0d got %0d", $time, w.acc_y,
                         $signed(d[55:28]));
                errors++;
            end
            if (d[83:56] !== w.acc_z) begin
                $display("%0t: accel_z expected %0d got %0d", $time, w.acc_z,
                         $signed(d[83:56]));
                errors++;
            end
            if (d[100:84] !== w.pitch) begin
                $display("%0t: pitch expected %0d got %0d", $time, w.pitch,
                         $signed(d[100:84]));
                errors++;
            end
            if (d[117:101] !== w.roll) begin
                $display("%0t: roll expected %0d got %0d", $time, w.roll,
                         $signed(d[117:101]));
                errors++;
            end
            if (d[133:118] !== w.pitch_ofs) begin
                $display("%0t: pitch_offset expected %0d got %0d", $time, w.pitch_ofs,
                         $signed(d[133:118]));
                errors++;
            end
            if (d[149:134] !== w.roll_ofs) begin
                $display("%0t: roll_offset expected %0d got %0d", $time, w.roll_ofs,
                         $signed(d[149:134]));
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;   // raw_x, raw_y, raw_z, pitch_offset_in, roll_offset_in
    logic [1:0]   s_tuser;   // cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;   // accel_x..z, pitch, roll, pitch_offset, roll_offset, pad
    logic         cfg_we;
    logic [1:0]   cfg_idx;
    logic [GAIN_W-1:0] cfg_wdata;

    tilt_scoreboard sb = new();
    int cycles = 0;
    bit stimulus_done = 0;

    accel_tilt_pitch_roll i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // monitor: inputs are noted before results of the same edge are checked,
    // a result at that edge always belongs to an older word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_word(m_tdata);
        end
    end

    // receiver: random backpressure in changing modes, one long hold-off
    initial begin
        int hold, mode, span;
        bit pressed;
        hold = 0; mode = 0; span = 0; pressed = 0;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(100, 800);
            end
            span--;
            if (!pressed && cycles > 4000) begin
                // long stall so the block fills up and blocks its input
                pressed = 1;
                hold = 1500;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 0;
            end else if (mode == 0) begin
                m_tready <= 1;
            end else if (mode == 1) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else if ($urandom_range(0, 9) == 0) begin
                hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(1, 8);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // offer one word, with a random gap first; returns at the accepting edge
    task automatic send_word(logic [1:0] cmd, logic [79:0] data);
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            9: gap = $urandom_range(20, 200);
            default: gap = $urandom_range(1, 6);
        endcase
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send_word(CMD_SAMPLE, {32'($urandom()), z, y, x});
    endtask

    task automatic send_offsets(logic [1:0] cmd, logic [15:0] p, logic [15:0] r);
        send_word(cmd, {r, p, 16'($urandom()), 32'($urandom())});
    endtask

    // wait until every expected word has come back, then let the block settle;
    // a clock edge first so the monitor has noted the last accepted word
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_gain(logic [1:0] idx, logic [GAIN_W-1:0] value);
        cfg_we    <= 1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_gain(idx, value);
        @(posedge aclk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(int phase, int axis);
        if (phase == 1) return '1;
        if (phase == 2) return '0;
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return 20'(63000 + $urandom_range(0, 1000));
            default: return 20'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 16'($urandom());
            1: return 16'sd23040;
            2: return -16'sd23040;
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    initial begin
        int k;
        aresetn   = 0;
        s_tvalid  = 0;
        s_tuser   = CMD_SAMPLE;
        s_tdata   = '0;
        cfg_we    = 0;
        cfg_idx   = REG_GAIN_X;
        cfg_wdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        repeat (2) @(posedge aclk);

        // directed: reset gains, field extremes, zero vector, every command
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7fff, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h0100, 16'hff00, 16'h4000);
        send_offsets(CMD_ZERO, 16'h5555, 16'haaaa);
        send_sample(16'h0200, 16'h0300, 16'h4000);
        send_offsets(CMD_LOAD, 16'h7fff, 16'h8000);
        send_offsets(CMD_LOAD, 16'sd23040, -16'sd23040);
        send_offsets(CMD_LOAD, 16'sd23041, -16'sd23041);
        send_offsets(CMD_LOAD, 16'h0000, 16'hffff);
        send_offsets(2'd3, 16'h1234, 16'h4321);
        send_sample(16'hc000, 16'h2000, 16'h0001);
        send_offsets(CMD_ZERO, 16'h0000, 16'h0000);
        send_offsets(2'd3, 16'h0000, 16'h0000);
        drain();

        // random phases, each under its own gain setting
        for (int phase = 1; phase <= 6; phase++) begin
            for (int a = 0; a < 3; a++) write_gain(2'(a), pick_gain(phase, a));
            for (int n = 0; n < RAND_WORDS / 6; n++) begin
                k = $urandom_range(0, 99);
                if (k < 62)      send_sample(pick_raw(), pick_raw(), pick_raw());
                else if (k < 74) send_offsets(CMD_ZERO, 16'($urandom()), 16'($urandom()));
                else if (k < 95) send_offsets(CMD_LOAD, pick_offset(), pick_offset());
                else             send_offsets(2'd3, 16'($urandom()), 16'($urandom()));
            end
            drain();
        end

        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (sb.expected_words.size() != 0)
                $display("%0t: %0d result words never arrived", $time,
                         sb.expected_words.size());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
